// ===== design/soundex_token_match_counter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// soundex token match counter assertion macros
// shared property wrappers for the port checker, sampled on clk, off in rst
// ----------------------------------------------------------------------------
`ifndef SOUNDEX_TOKEN_MATCH_COUNTER_UNIT_ASSERT_SVH
`define SOUNDEX_TOKEN_MATCH_COUNTER_UNIT_ASSERT_SVH

// same-cycle implication
`define SCMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/scmc_pkg.sv =====
// ----------------------------------------------------------------------------
// scmc_pkg
// shared types, constants and the soundex digit lookup
// ----------------------------------------------------------------------------
package scmc_pkg;

  localparam int CODE_LEN   = 4;
  localparam int NDIG       = CODE_LEN - 1;
  localparam int COUNT_BITS = 16;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 3;
  localparam int OUT_W      = 16;
  localparam int FILL_W     = $clog2(NDIG + 1);
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_ONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_TWO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_THREE = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2c;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_GAP   = 8'h20;

  // classified byte passed from front to back
  typedef struct packed {
    logic                last;
    logic                split;
    logic [CHAR_W-1:0]   letter;
    logic [DIGIT_W-1:0]  digit;
  } scmc_item_t;

  typedef logic [NDIG-1:0][DIGIT_W-1:0] digits_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    case (c)
      "b", "f", "p", "v":                     d = 3'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": d = 3'd2;
      "d", "t":                               d = 3'd3;
      "l":                                    d = 3'd4;
      "m", "n":                               d = 3'd5;
      "r":                                    d = 3'd6;
      default:                                d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/scmc_front.sv =====
// ----------------------------------------------------------------------------
// scmc_front
// takes text bytes, classifies them and registers one item for the queue
// ----------------------------------------------------------------------------
module scmc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scmc_pkg::CHAR_W-1:0] in_char,
  input  logic                        in_last,
  output logic                        push,
  input  logic                        push_ready,
  output scmc_pkg::scmc_item_t        push_item
);
  import scmc_pkg::*;

  logic       vld;
  scmc_item_t item;
  scmc_item_t item_next;
  logic       is_lower;

  assign is_lower = (in_char >= CHAR_LC_A) && (in_char <= CHAR_LC_Z);

  always_comb begin
    item_next.last   = in_last;
    item_next.split  = (in_char == CHAR_COMMA) || (in_char == CHAR_SPACE) ||
                       (in_char == CHAR_DOT);
    item_next.letter = is_lower ? (in_char - CASE_GAP) : in_char;
    item_next.digit  = digit_of(in_char);
  end

  assign in_ready  = !vld || push_ready;
  assign push      = vld;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (push_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

// ===== design/scmc_queue.sv =====
// ----------------------------------------------------------------------------
// scmc_queue
// small register queue between the classifier and the token logic
// ----------------------------------------------------------------------------
module scmc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 push_ready,
  input  scmc_pkg::scmc_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop,
  output scmc_pkg::scmc_item_t pop_item
);
  import scmc_pkg::*;

  scmc_item_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]     wr_ptr;
  logic [Q_PTR_W-1:0]     rd_ptr;
  logic [Q_CNT_W-1:0]     fill;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (fill != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/scmc_back.sv =====
// ----------------------------------------------------------------------------
// scmc_back
// token state, soundex code build, target compare, match count and result
// ----------------------------------------------------------------------------
module scmc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [scmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scmc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            item_valid,
  output logic                            item_pop,
  input  scmc_pkg::scmc_item_t            item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [scmc_pkg::OUT_W-1:0]      out_count
);
  import scmc_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // target code
  logic [CHAR_W-1:0]     tgt_first;
  digits_t               tgt_digits;

  // token state
  logic                  inside_token;
  logic [FILL_W-1:0]     code_fill;
  logic [CHAR_W-1:0]     token_letter;
  digits_t               token_digits;
  logic [DIGIT_W-1:0]    previous_code;
  logic [COUNT_BITS-1:0] match_total;

  logic                  inside_next;
  logic [FILL_W-1:0]     fill_next;
  logic [CHAR_W-1:0]     letter_next;
  digits_t               digits_next;
  logic [DIGIT_W-1:0]    prev_next;
  logic [COUNT_BITS-1:0] match_total_next;
  logic                  close_now;
  logic                  hit;
  logic                  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_first  <= '0;
      tgt_digits <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_CHAR:  tgt_first     <= cfg_data;
        REG_DIGIT_ONE:   tgt_digits[0] <= cfg_data[DIGIT_W-1:0];
        REG_DIGIT_TWO:   tgt_digits[1] <= cfg_data[DIGIT_W-1:0];
        REG_DIGIT_THREE: tgt_digits[2] <= cfg_data[DIGIT_W-1:0];
        default:         tgt_first     <= tgt_first;
      endcase
    end
  end

  // a last item needs the result register free, others pass regardless
  assign item_pop = item_valid && (!item.last || !out_valid || out_ready);
  assign take     = item_pop;

  always_comb begin
    inside_next = inside_token;
    fill_next   = code_fill;
    letter_next = token_letter;
    digits_next = token_digits;
    prev_next   = previous_code;
    if (item.split) begin
      inside_next = 1'b0;
    end else if (!inside_token) begin
      inside_next = 1'b1;
      letter_next = item.letter;
      fill_next   = '0;
      digits_next = '0;
      prev_next   = item.digit;
    end else if (code_fill < FILL_W'(NDIG)) begin
      if ((item.digit != '0) && (item.digit != previous_code)) begin
        digits_next[code_fill] = item.digit;
        fill_next              = code_fill + 1'b1;
      end
      prev_next = item.digit;
    end
    // the end byte also finishes a token it opened or extended
    close_now        = (item.split && inside_token) || (item.last && inside_next);
    hit              = close_now && (letter_next == tgt_first) &&
                       (digits_next == tgt_digits);
    match_total_next = match_total + COUNT_BITS'(hit && (match_total != COUNT_MAX));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_token <= 1'b0;
      code_fill    <= '0;
      match_total  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (take && item.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (item.last) begin
          inside_token <= 1'b0;
          code_fill    <= '0;
          match_total  <= '0;
        end else begin
          inside_token <= inside_next;
          code_fill    <= fill_next;
          match_total  <= match_total_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      token_letter  <= letter_next;
      token_digits  <= digits_next;
      previous_code <= prev_next;
      if (item.last) begin
        out_count <= OUT_W'(match_total_next);
      end
    end
  end

endmodule

// ===== design/soundex_token_match_counter_unit.sv =====
// ----------------------------------------------------------------------------
// soundex_token_match_counter_unit
// counts tokens of a byte stream whose 4-character soundex code hits a target
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the queue has room; ',', space and '.'
// split tokens, and the byte with tlast closes the text and yields one beat
// with the saturating match count, after which the count starts over at
// zero. A byte goes through the classifier register, a 4-entry queue and
// the token stage; the queue lets the classifier keep taking bytes while a
// count beat waits on m_tready, and only the next tlast byte waits for the
// result register. The user must write the target registers only while
// idle, through cfg_we/cfg_index/cfg_data; the block does not enforce it.
module soundex_token_match_counter_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [scmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scmc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] text_char
  input  logic                            s_tlast,   // end_of_text
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata    // [15:0] match_count
);
  import scmc_pkg::*;

  logic       push;
  logic       push_ready;
  scmc_item_t push_item;
  logic       pop_valid;
  logic       pop;
  scmc_item_t pop_item;

  scmc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_char    (s_tdata),
    .in_last    (s_tlast),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  scmc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  scmc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (pop_valid),
    .item_pop   (pop),
    .item       (pop_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_count  (m_tdata)
  );

endmodule

// ===== design/scmc_checker.sv =====
// ----------------------------------------------------------------------------
// scmc_checker
// port-level checks for the soundex token match counter, bound to the top
// ----------------------------------------------------------------------------
`include "soundex_token_match_counter_unit_assert.svh"

module scmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a count beat held back keeps its value
  `SCMC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "count beat changed while stalled")

  // nothing pending right after reset
  `SCMC_ASSERT_NOW(a_out_clear, $fell(rst), !m_tvalid, "count beat present after reset")

  // classifier stage is empty after reset and takes a byte at once
  `SCMC_ASSERT_NOW(a_in_open, $fell(rst), s_tready, "input not ready after reset")

endmodule

bind soundex_token_match_counter_unit scmc_checker u_scmc_checker (.*);
